[src/lmt_pkg.sv]
// Shared types and constants for the LCD mode timing and STAT interrupt block.
package lmt_pkg;

	localparam int unsigned VISIBLE_LINES = 144;
	localparam int unsigned DOTS_PER_LINE = 456;

	localparam logic [9:0] DOTS_LINE       = 10'(DOTS_PER_LINE);
	localparam logic [7:0] VIS_LINE        = 8'(VISIBLE_LINES);
	localparam logic [9:0] OAM_DOTS        = 10'd80;
	localparam logic [9:0] DRAW_BASE       = 10'd172;
	localparam logic [9:0] DRAW_PER_SPRITE = 10'd8;
	localparam logic [9:0] DRAW_CAP        = 10'd289;
	localparam logic [7:0] LAST_LINE       = 8'd153;
	localparam logic [3:0] MAX_SPRITES     = 4'd10;

	// bit positions in stat_irq_enables
	localparam int unsigned EN_LYC    = 0;
	localparam int unsigned EN_HBLANK = 1;
	localparam int unsigned EN_OAM    = 2;
	localparam int unsigned EN_VBLANK = 3;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAT_ENABLES = 1'd1;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} lmt_mode_t;

	typedef struct packed {
		lmt_mode_t   mode;
		logic [7:0]  line;
		logic [9:0]  cnt;
		logic [8:0]  draw_len;
		logic        match;
	} lmt_walk_t;

	typedef struct packed {
		logic        stat;
		logic        vblank;
		logic        render;
		logic [7:0]  draw_line;
	} lmt_evt_t;

	typedef struct packed {
		logic [7:0]  line_compare;
		logic [3:0]  enables;
	} lmt_cfg_t;

	typedef struct packed {
		lmt_mode_t   mode;
		logic [7:0]  line;
		logic        match;
		logic        stat;
		logic        vblank;
		logic        render;
		logic [7:0]  draw_line;
	} lmt_res_t;

endpackage

[src/lcd_mode_timing_and_stat_irq.sv]
// Top level: request registers, configuration registers and tick logic.
// An accepted request is held in the input register, then in the result register on m_tdata.
// Throughput: one request per cycle unless m_tready stalls; the three mode crossings of a
// tick are one cascade of compare-subtract steps between the input and result registers.
// Reset (arst_n low): mode OAM scan, line 0, dot count 0, LCD seen as off,
// both configuration registers 0, both channels empty.
module lcd_mode_timing_and_stat_irq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// elapsed_dots[7:0], lcd_on[8], sprites_on_line[12:9], stat_already_pending[13]
	input  logic [15:0]                      s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// lcd_mode[1:0], current_line[9:2], line_match[10], stat_irq[11], vblank_irq[12],
	// render_start[13], render_line_number[21:14]
	output logic [23:0]                      m_tdata,
	input  logic                             cfg_wr_en,
	input  logic [lmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import lmt_pkg::*;

	logic       valid_s1;
	logic [7:0] dots_s1;
	logic       on_s1;
	logic [3:0] sprites_s1;
	logic       pending_s1;
	logic       valid_s2;
	lmt_res_t   res_s2;
	lmt_res_t   res;
	lmt_cfg_t   cfg_q;
	logic       adv;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LINE_COMPARE: cfg_q.line_compare <= cfg_wdata[7:0];
				CFG_STAT_ENABLES: cfg_q.enables <= cfg_wdata[3:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dots_s1 <= s_tdata[7:0];
			on_s1 <= s_tdata[8];
			sprites_s1 <= s_tdata[12:9];
			pending_s1 <= s_tdata[13];
		end
	end

	lmt_tick u_tick (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.dots(dots_s1),
		.on(on_s1),
		.sprites(sprites_s1),
		.pending(pending_s1),
		.cfg(cfg_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {2'b00, res_s2.draw_line, res_s2.render, res_s2.vblank, res_s2.stat,
		res_s2.match, res_s2.line, res_s2.mode};

`ifndef NO_ASSERTIONS
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_s2.line <= LAST_LINE)
		else $error("current line beyond last line");

	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.vblank |-> res_s2.line == VIS_LINE && res_s2.mode == MODE_VBLANK)
		else $error("vblank interrupt without entering first vblank line");

	a_render_visible: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.render |-> res_s2.draw_line < VIS_LINE)
		else $error("render requested for a non-visible line");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stalled request dropped from input register");
`endif

endmodule

[src/lmt_step.sv]
// One mode boundary crossing: compare dot count with mode length and advance.
module lmt_step (
	input  lmt_pkg::lmt_walk_t cur,
	input  lmt_pkg::lmt_cfg_t  cfg,
	input  logic               pending,
	input  logic [8:0]         new_draw_len,
	output lmt_pkg::lmt_walk_t nxt,
	output lmt_pkg::lmt_evt_t  evt
);
	import lmt_pkg::*;

	logic [9:0] used;
	logic [9:0] len;
	logic [7:0] line_inc;
	logic       hit;

	always_comb begin
		used = OAM_DOTS + 10'(cur.draw_len);
		unique case (cur.mode)
			MODE_OAM:    len = OAM_DOTS;
			MODE_DRAW:   len = 10'(cur.draw_len);
			MODE_HBLANK: len = (used >= DOTS_LINE) ? 10'd0 : DOTS_LINE - used;
			MODE_VBLANK: len = DOTS_LINE;
		endcase
		line_inc = cur.line + 8'd1;
		nxt = cur;
		evt = '0;
		hit = 1'b0;
		if (cur.cnt >= len) begin
			nxt.cnt = cur.cnt - len;
			unique case (cur.mode)
				MODE_OAM: begin
					nxt.mode = MODE_DRAW;
					nxt.draw_len = new_draw_len;
					evt.render = 1'b1;
					evt.draw_line = cur.line;
				end
				MODE_DRAW: begin
					nxt.mode = MODE_HBLANK;
				end
				MODE_HBLANK: begin
					nxt.line = line_inc;
					if (line_inc >= VIS_LINE) begin
						nxt.mode = MODE_VBLANK;
						evt.vblank = 1'b1;
					end else begin
						nxt.mode = MODE_OAM;
					end
				end
				MODE_VBLANK: begin
					if (line_inc > LAST_LINE) begin
						nxt.line = 8'd0;
						nxt.mode = MODE_OAM;
					end else begin
						nxt.line = line_inc;
					end
				end
			endcase
			nxt.match = (nxt.line == cfg.line_compare);
			hit = (cfg.enables[EN_VBLANK] && nxt.mode == MODE_VBLANK) ||
				(cfg.enables[EN_OAM] && nxt.mode == MODE_OAM) ||
				(cfg.enables[EN_HBLANK] && nxt.mode == MODE_HBLANK) ||
				(cfg.enables[EN_LYC] && nxt.match);
			evt.stat = hit && !pending;
		end
	end

endmodule

[src/lmt_tick.sv]
// Timing state registers and the three-crossing cascade for one tick.
module lmt_tick (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        dots,
	input  logic              on,
	input  logic [3:0]        sprites,
	input  logic              pending,
	input  lmt_pkg::lmt_cfg_t cfg,
	output lmt_pkg::lmt_res_t res
);
	import lmt_pkg::*;

	lmt_walk_t  walk_q;
	lmt_walk_t  walk_d;
	logic       was_on_q;
	logic       was_on_d;
	lmt_walk_t  w0, w1, w2, w3;
	lmt_evt_t   e0, e1, e2;
	logic [3:0] ns;
	logic [9:0] dl_full;
	logic [8:0] new_dl;

	always_comb begin
		ns = (sprites > MAX_SPRITES) ? MAX_SPRITES : sprites;
		dl_full = DRAW_BASE + 10'(ns) * DRAW_PER_SPRITE;
		new_dl = (dl_full > DRAW_CAP) ? DRAW_CAP[8:0] : dl_full[8:0];
		w0 = walk_q;
		if (!was_on_q) begin
			w0.mode = MODE_OAM;
			w0.line = 8'd0;
			w0.cnt = 10'd0;
		end
		w0.cnt = w0.cnt + 10'(dots);
	end

	lmt_step u_step0 (.cur(w0), .cfg(cfg), .pending(pending), .new_draw_len(new_dl),
		.nxt(w1), .evt(e0));
	lmt_step u_step1 (.cur(w1), .cfg(cfg), .pending(pending), .new_draw_len(new_dl),
		.nxt(w2), .evt(e1));
	lmt_step u_step2 (.cur(w2), .cfg(cfg), .pending(pending), .new_draw_len(new_dl),
		.nxt(w3), .evt(e2));

	always_comb begin
		res = '0;
		if (on) begin
			walk_d = w3;
			was_on_d = 1'b1;
			res.stat = e0.stat | e1.stat | e2.stat;
			res.vblank = e0.vblank | e1.vblank | e2.vblank;
			res.render = e0.render | e1.render | e2.render;
			priority if (e2.render) res.draw_line = e2.draw_line;
			else if (e1.render) res.draw_line = e1.draw_line;
			else res.draw_line = e0.draw_line;
		end else begin
			walk_d = walk_q;
			was_on_d = 1'b0;
			if (was_on_q) begin
				walk_d.line = 8'd0;
				walk_d.mode = MODE_HBLANK;
				walk_d.cnt = 10'd0;
			end
		end
		res.mode = walk_d.mode;
		res.line = walk_d.line;
		res.match = walk_d.match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '{mode: MODE_OAM, line: 8'd0, cnt: 10'd0, draw_len: 9'd0, match: 1'b0};
			was_on_q <= 1'b0;
		end else if (adv) begin
			walk_q <= walk_d;
			was_on_q <= was_on_d;
		end
	end

endmodule
